// ===== rtl/core/rttp_pkg.sv =====
// ----------------------------------------------------------------------------
// Text-to-integer parser package
// Shared widths, number format codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rttp_pkg;

    // Widths of the accumulator and of the request and result fields.
    localparam int unsigned AccWidth  = 128;
    localparam int unsigned HalfWidth = 64;
    localparam int unsigned CodeWidth = 16;
    localparam int unsigned FmtWidth  = 3;

    // Number format register codes.
    typedef logic [FmtWidth-1:0] fmt_t;
    localparam fmt_t FMT_HEX            = 3'd0;
    localparam fmt_t FMT_OCTAL          = 3'd1;
    localparam fmt_t FMT_BINARY         = 3'd2;
    localparam fmt_t FMT_DECIMAL        = 3'd3;
    localparam fmt_t FMT_SIGNED_DECIMAL = 3'd4;
    localparam fmt_t FMT_CHARACTER      = 3'd5;

    typedef logic [CodeWidth-1:0] code_t;
    typedef logic [AccWidth-1:0]  acc_t;

    // Character codes that steer the prefix and sign handling.
    localparam code_t CHAR_ZERO  = 16'h0030;
    localparam code_t CHAR_MINUS = 16'h002D;
    localparam code_t CHAR_X     = 16'h0078;
    localparam code_t CHAR_NINE  = 16'h0039;
    localparam code_t CHAR_UPPER_A = 16'h0041;
    localparam code_t CHAR_UPPER_F = 16'h0046;
    localparam code_t CHAR_LOWER_A = 16'h0061;
    localparam code_t CHAR_LOWER_F = 16'h0066;

endpackage : rttp_pkg

`default_nettype wire

// ===== rtl/core/rttp_char_if.sv =====
// ----------------------------------------------------------------------------
// Character request channel
// Valid/ready channel carrying one character code unit per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rttp_char_if
    import rttp_pkg::*;
();
    logic  valid;
    logic  ready;
    code_t char_code;
    logic  char_present;
    logic  last_char;

    modport source (output valid, output char_code, output char_present,
                    output last_char, input ready);
    modport sink   (input valid, input char_code, input char_present,
                    input last_char, output ready);
endinterface : rttp_char_if

`default_nettype wire

// ===== rtl/core/rttp_result_if.sv =====
// ----------------------------------------------------------------------------
// Parsed value result channel
// Valid/ready channel carrying the 128-bit value and its known flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rttp_result_if
    import rttp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [HalfWidth-1:0] value_low;
    logic [HalfWidth-1:0] value_high;
    logic                 value_known;

    modport source (output valid, output value_low, output value_high,
                    output value_known, input ready);
    modport sink   (input valid, input value_low, input value_high,
                    input value_known, output ready);
endinterface : rttp_result_if

`default_nettype wire

// ===== rtl/core/rttp_digit_step.sv =====
// ----------------------------------------------------------------------------
// Digit accumulation step
// Decodes one character and folds it into the accumulator in the current
// number format: shift and OR for the power-of-two radices and character
// format, times ten plus digit for decimal.
// ----------------------------------------------------------------------------
`default_nettype none

module rttp_digit_step
    import rttp_pkg::*;
(
    input  wire fmt_t  fmt,
    input  wire acc_t  base,
    input  wire code_t code,
    output acc_t       next_acc,
    output logic       is_digit
);

    logic       hex_ok;
    logic [3:0] hex_digit;
    acc_t       hex_ext;
    acc_t       code_ext;

    // Hex digit decode; only ASCII 0-9, A-F and a-f are digits.
    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (code >= CHAR_ZERO && code <= CHAR_NINE)
        begin
            hex_digit = 4'(code - CHAR_ZERO);
        end
        else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_F)
        begin
            hex_digit = 4'(code - CHAR_UPPER_A + 16'd10);
        end
        else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_F)
        begin
            hex_digit = 4'(code - CHAR_LOWER_A + 16'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign hex_ext  = {{(AccWidth-4){1'b0}}, hex_digit};
    assign code_ext = {{(AccWidth-CodeWidth){1'b0}}, code};

    // Character format accepts every code; the others need a hex digit.
    assign is_digit = (fmt == FMT_CHARACTER) ? 1'b1 : hex_ok;

    // Fold the digit into the accumulator; unused formats leave it alone.
    always_comb
    begin
        unique case (fmt) inside
            FMT_HEX:       next_acc = (base << 4) | hex_ext;
            FMT_OCTAL:     next_acc = (base << 3) | hex_ext;
            FMT_BINARY:    next_acc = (base << 1) | hex_ext;
            FMT_DECIMAL, FMT_SIGNED_DECIMAL:
                           next_acc = (base << 3) + (base << 1) + hex_ext;
            FMT_CHARACTER: next_acc = (base << 8) | code_ext;
            default:       next_acc = base;
        endcase
    end

endmodule : rttp_digit_step

`default_nettype wire

// ===== rtl/core/radix_text_to_int128_parser.sv =====
// ----------------------------------------------------------------------------
// Multi-radix text to 128-bit integer parser
// Accumulates a text number one character per request into a wrapping
// 128-bit value, with optional 0x prefix and minus sign.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Contents
//   chars     in         valid/ready    char_code, char_present, last_char
//   result    out        valid/ready    value_low, value_high, value_known
//   cfg       in         write enable   number_format (3 bits)
//
// One character is taken every cycle while the hold stage is free; the
// accumulator step is a single shift-or or times-ten add between the parse
// state and its register. A last character moves the value into a hold
// stage, from which the negated or plain value moves into the output register.
// Reset clears the parse state, both stage valid flags and the format register.
// A stalled result stops new requests only once the hold stage is full too.
//
`default_nettype none

module radix_text_to_int128_parser
    import rttp_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    rttp_char_if.sink      chars,
    rttp_result_if.source  result,
    input  wire            cfg_write_en,
    input  wire fmt_t      cfg_write_data
);

    typedef enum logic [2:0] {
        PHASE_START,
        PHASE_ZERO,
        PHASE_SIGN,
        PHASE_DIGITS,
        PHASE_STOPPED
    } phase_t;

    fmt_t   fmt_reg;
    phase_t phase_reg, phase_next;
    acc_t   acc_reg, acc_next;
    logic   minus_reg, minus_next;
    logic   known_reg, known_next;

    // Hold stage between the accumulator and the output register.
    logic   hold_valid_reg;
    acc_t   hold_value_reg;
    logic   hold_minus_reg;
    logic   hold_known_reg;

    // Output register.
    logic   out_valid_reg;
    acc_t   out_value_reg;
    logic   out_known_reg;

    logic   in_fire;
    logic   hold_advance;
    acc_t   zero_acc;
    acc_t   step_base;
    acc_t   step_acc;
    logic   step_digit;
    acc_t   final_acc;
    logic   take_digit;

    // Pipeline flow control.
    assign hold_advance = hold_valid_reg && (!out_valid_reg || result.ready);
    assign chars.ready  = !hold_valid_reg || hold_advance;
    assign in_fire      = chars.valid && chars.ready;

    // A held leading zero on an empty accumulator leaves zero, or the raw
    // code of '0' in character format.
    assign zero_acc  = (fmt_reg == FMT_CHARACTER)
                       ? {{(AccWidth-CodeWidth){1'b0}}, CHAR_ZERO} : '0;
    assign step_base = (phase_reg == PHASE_ZERO) ? zero_acc : acc_reg;

    rttp_digit_step u_step (
        .fmt      (fmt_reg),
        .base     (step_base),
        .code     (chars.char_code),
        .next_acc (step_acc),
        .is_digit (step_digit)
    );

    // Prefix, sign and digit sequencing for one character.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        known_next = known_reg | chars.char_present;
        take_digit = 1'b0;

        if (chars.char_present)
        begin
            unique case (phase_reg)
                PHASE_START:
                begin
                    if (chars.char_code == CHAR_ZERO)
                    begin
                        phase_next = PHASE_ZERO;
                    end
                    else if (chars.char_code == CHAR_MINUS)
                    begin
                        minus_next = 1'b1;
                        phase_next = PHASE_DIGITS;
                    end
                    else
                    begin
                        take_digit = 1'b1;
                    end
                end
                PHASE_ZERO:
                begin
                    if (chars.char_code == CHAR_X)
                    begin
                        phase_next = PHASE_SIGN;
                    end
                    else
                    begin
                        acc_next   = zero_acc;
                        take_digit = 1'b1;
                    end
                end
                PHASE_SIGN:
                begin
                    if (chars.char_code == CHAR_MINUS)
                    begin
                        minus_next = 1'b1;
                        phase_next = PHASE_DIGITS;
                    end
                    else
                    begin
                        take_digit = 1'b1;
                    end
                end
                PHASE_DIGITS:
                begin
                    take_digit = 1'b1;
                end
                PHASE_STOPPED:
                begin
                    take_digit = 1'b0;
                end
                default:
                begin
                    take_digit = 1'b0;
                end
            endcase
        end

        if (take_digit)
        begin
            if (step_digit)
            begin
                acc_next   = step_acc;
                phase_next = PHASE_DIGITS;
            end
            else
            begin
                phase_next = PHASE_STOPPED;
            end
        end

        // A string ending on the held zero takes it as a digit.
        final_acc = (phase_next == PHASE_ZERO) ? zero_acc : acc_next;
    end

    // Format register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_HEX;
        end
        else if (cfg_write_en)
        begin
            fmt_reg <= cfg_write_data;
        end
    end

    // Parse state; a last character returns it to the start of a string.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_START;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            known_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (chars.last_char)
            begin
                phase_reg <= PHASE_START;
                acc_reg   <= '0;
                minus_reg <= 1'b0;
                known_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                minus_reg <= minus_next;
                known_reg <= known_next;
            end
        end
    end

    // Hold stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_fire && chars.last_char)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (hold_advance)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Hold stage payload.
    always_ff @(posedge clk)
    begin
        if (in_fire && chars.last_char)
        begin
            hold_value_reg <= final_acc;
            hold_minus_reg <= minus_next;
            hold_known_reg <= known_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (hold_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, negated in two's complement when a minus was seen.
    always_ff @(posedge clk)
    begin
        if (hold_advance)
        begin
            out_value_reg <= hold_minus_reg ? (~hold_value_reg + acc_t'(1))
                                            : hold_value_reg;
            out_known_reg <= hold_known_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.value_low   = out_value_reg[HalfWidth-1:0];
    assign result.value_high  = out_value_reg[AccWidth-1:HalfWidth];
    assign result.value_known = out_known_reg;

endmodule : radix_text_to_int128_parser

`default_nettype wire

// ===== test/rttp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text-to-integer parser checker
// Watches the character and result channels and the format register writes,
// runs its own model of the parse for every accepted character request and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module rttp_checker
    import rttp_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    rttp_char_if        chars,
    rttp_result_if      result,
    input  wire         cfg_write_en,
    input  wire fmt_t   cfg_write_data,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    // Where the parse stands within the current string.
    typedef enum logic [2:0] {
        LEAD_EMPTY,
        LEAD_ZERO,
        LEAD_PREFIX,
        IN_DIGITS,
        HALTED
    } lead_state_t;

    typedef struct packed {
        logic [HalfWidth-1:0] low;
        logic [HalfWidth-1:0] high;
        logic                 known;
    } parsed_value_t;

    fmt_t          cur_format;
    acc_t          acc;
    lead_state_t   lead_state;
    logic          negative;
    logic          any_char;
    parsed_value_t parsed_values[$];

    // Hex digit decoding of a code unit; only ASCII digits and letters count.
    function automatic logic decode_hex(input code_t c, output logic [3:0] v);
        v = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            v = 4'(c - CHAR_ZERO);
            return 1'b1;
        end
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            v = 4'(c - CHAR_UPPER_A + 16'd10);
            return 1'b1;
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            v = 4'(c - CHAR_LOWER_A + 16'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Folds one character into the accumulator; returns 0 when it stops the parse.
    function automatic logic fold_char(input code_t c);
        logic [3:0] digit;
        logic       is_digit;
        is_digit = decode_hex(c, digit);
        if (cur_format != FMT_CHARACTER && !is_digit)
            return 1'b0;
        case (cur_format)
            FMT_HEX:                         acc = (acc << 4) | acc_t'(digit);
            FMT_OCTAL:                       acc = (acc << 3) | acc_t'(digit);
            FMT_BINARY:                      acc = (acc << 1) | acc_t'(digit);
            FMT_DECIMAL, FMT_SIGNED_DECIMAL: acc = acc * acc_t'(10) + acc_t'(digit);
            FMT_CHARACTER:                   acc = (acc << 8) | acc_t'(c);
            default:                         ;
        endcase
        return 1'b1;
    endfunction

    function automatic lead_state_t digit_state(input code_t c);
        return fold_char(c) ? IN_DIGITS : HALTED;
    endfunction

    function automatic void clear_string();
        acc        = '0;
        lead_state = LEAD_EMPTY;
        negative   = 1'b0;
        any_char   = 1'b0;
    endfunction

    // Advances the parse by one accepted request and queues the value on the last.
    function automatic void take_request(input code_t c, input logic present,
                                         input logic last);
        parsed_value_t value;
        if (present)
        begin
            any_char = 1'b1;
            case (lead_state)
                LEAD_EMPTY:
                    if (c == CHAR_ZERO)
                        lead_state = LEAD_ZERO;
                    else if (c == CHAR_MINUS)
                    begin
                        negative   = 1'b1;
                        lead_state = IN_DIGITS;
                    end
                    else
                        lead_state = digit_state(c);
                LEAD_ZERO:
                    if (c == CHAR_X)
                        lead_state = LEAD_PREFIX;
                    else
                    begin
                        void'(fold_char(CHAR_ZERO));
                        lead_state = digit_state(c);
                    end
                LEAD_PREFIX:
                    if (c == CHAR_MINUS)
                    begin
                        negative   = 1'b1;
                        lead_state = IN_DIGITS;
                    end
                    else
                        lead_state = digit_state(c);
                IN_DIGITS:
                    lead_state = digit_state(c);
                default:
                    ;
            endcase
        end
        if (last)
        begin
            // A zero still held at the end is a digit of its own.
            if (lead_state == LEAD_ZERO)
                void'(fold_char(CHAR_ZERO));
            if (negative)
                acc = ~acc + acc_t'(1);
            value.low   = acc[HalfWidth-1:0];
            value.high  = acc[AccWidth-1:HalfWidth];
            value.known = any_char;
            parsed_values.push_back(value);
            clear_string();
        end
    endfunction

    // Compare results first, then track the format and the character requests.
    always @(posedge clk or negedge rst_n)
    begin
        parsed_value_t want;
        int unsigned   errs;
        if (!rst_n)
        begin
            cur_format = FMT_HEX;
            clear_string();
            parsed_values.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (result.valid && result.ready)
            begin
                if (parsed_values.size() == 0)
                begin
                    $error("result with nothing expected: value_low %h value_high %h known %b",
                           result.value_low, result.value_high, result.value_known);
                    errs++;
                end
                else
                begin
                    want = parsed_values.pop_front();
                    if (result.value_low !== want.low)
                    begin
                        $error("value_low: expected %h, actual %h",
                               want.low, result.value_low);
                        errs++;
                    end
                    if (result.value_high !== want.high)
                    begin
                        $error("value_high: expected %h, actual %h",
                               want.high, result.value_high);
                        errs++;
                    end
                    if (result.value_known !== want.known)
                    begin
                        $error("value_known: expected %b, actual %b",
                               want.known, result.value_known);
                        errs++;
                    end
                end
            end
            if (cfg_write_en)
                cur_format = cfg_write_data;
            if (chars.valid && chars.ready)
                take_request(chars.char_code, chars.char_present, chars.last_char);
            fail_count  <= fail_count + errs;
            outstanding <= parsed_values.size();
        end
    end

endmodule : rttp_checker

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text-to-integer parser testbench
// Streams directed and random strings through the parser in every number
// format, with random gaps on the character side and random stalls on the
// result side; the checker predicts and compares every parsed value.
// ----------------------------------------------------------------------------

module tb_top;
    import rttp_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 72;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned TIMEOUT_NS      = 6_000_000;

    // Format codes with no defined meaning still go through the register.
    localparam fmt_t FMT_SPARE_SIX   = 3'd6;
    localparam fmt_t FMT_SPARE_SEVEN = 3'd7;

    typedef struct {
        code_t code;
        logic  present;
        logic  last;
    } char_req_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_en;
    fmt_t        cfg_write_data;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned requests_sent;
    bit          quiet;

    rttp_char_if   chars_if ();
    rttp_result_if result_if ();

    radix_text_to_int128_parser u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .chars          (chars_if),
        .result         (result_if),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    rttp_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .chars          (chars_if),
        .result         (result_if),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // A digit that suits the format, now and then one beyond its radix.
    function automatic code_t pick_digit(input fmt_t f);
        int unsigned v;
        if (f == FMT_CHARACTER)
            return ($urandom_range(0, 3) == 0) ? code_t'($urandom)
                                               : code_t'($urandom_range(16'h20, 16'h7E));
        if ($urandom_range(0, 19) == 0)
            v = $urandom_range(0, 15);
        else
            case (f)
                FMT_OCTAL:                       v = $urandom_range(0, 7);
                FMT_BINARY:                      v = $urandom_range(0, 1);
                FMT_DECIMAL, FMT_SIGNED_DECIMAL: v = $urandom_range(0, 9);
                default:                         v = $urandom_range(0, 15);
            endcase
        if (v < 10)
            return CHAR_ZERO + code_t'(v);
        return (($urandom_range(0, 1) == 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + code_t'(v - 10);
    endfunction

    // Characters that upset the parse: prefix and sign marks, or anything at all.
    function automatic code_t pick_noise();
        case ($urandom_range(0, 4))
            0:       return CHAR_ZERO;
            1:       return CHAR_X;
            2:       return CHAR_MINUS;
            3:       return code_t'($urandom_range(0, 16'h7F));
            default: return code_t'($urandom);
        endcase
    endfunction

    // Presents one character request and waits until it is taken.
    task automatic send_char(input code_t code, input logic present, input logic last);
        int unsigned gap;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid        <= 1'b1;
        chars_if.char_code    <= code;
        chars_if.char_present <= present;
        chars_if.last_char    <= last;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Stops requests and waits until every parsed value has come out.
    task automatic wait_idle();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(input fmt_t f);
        wait_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= f;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // One random string: mostly well formed, some empty, some plain noise.
    task automatic send_random_string(input fmt_t f);
        char_req_t   reqs[$];
        char_req_t   item;
        int unsigned kind;
        int unsigned len;
        quiet = ($urandom_range(0, 4) == 0);
        kind  = $urandom_range(0, 99);
        if (kind < 12)
        begin
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                item = '{pick_noise(), ($urandom_range(0, 5) != 0), 1'b0};
                reqs.push_back(item);
            end
        end
        else if (kind >= 17)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                reqs.push_back('{CHAR_ZERO, 1'b1, 1'b0});
                reqs.push_back('{CHAR_X, 1'b1, 1'b0});
            end
            if ($urandom_range(0, 3) == 0)
                reqs.push_back('{CHAR_MINUS, 1'b1, 1'b0});
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(30, (f == FMT_BINARY) ? 135 : 45);
            else
                len = $urandom_range(0, 12);
            repeat (len)
            begin
                if ($urandom_range(0, 24) == 0)
                    reqs.push_back('{code_t'($urandom), 1'b0, 1'b0});
                reqs.push_back('{pick_digit(f), 1'b1, 1'b0});
            end
            // A broken tail: a stray character followed by more digits.
            if ($urandom_range(0, 7) == 0)
            begin
                reqs.push_back('{pick_noise(), 1'b1, 1'b0});
                repeat ($urandom_range(0, 3))
                    reqs.push_back('{pick_digit(f), 1'b1, 1'b0});
            end
        end
        // Empty strings and strings that end on an absent item.
        if (reqs.size() == 0 || $urandom_range(0, 9) == 0)
            reqs.push_back('{code_t'($urandom), 1'b0, 1'b0});
        reqs[reqs.size()-1].last = 1'b1;
        foreach (reqs[i])
            send_char(reqs[i].code, reqs[i].present, reqs[i].last);
    endtask

    // Result side: runs of ready with stalls of random length between them.
    initial
    begin
        int unsigned run_len;
        int unsigned stall;
        int unsigned r;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            result_if.ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            repeat (run_len) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 40)
                stall = 0;
            else if (r < 85)
                stall = $urandom_range(1, 3);
            else if (r < 97)
                stall = $urandom_range(4, 12);
            else
                stall = $urandom_range(30, 100);
            if (stall != 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        fmt_t        format_plan[10];
        int unsigned phase_start;
        format_plan = '{FMT_OCTAL, FMT_BINARY, FMT_DECIMAL, FMT_SIGNED_DECIMAL,
                        FMT_CHARACTER, FMT_SPARE_SIX, FMT_SPARE_SEVEN, FMT_HEX,
                        FMT_DECIMAL, FMT_CHARACTER};
        requests_sent = 0;
        quiet         = 1'b0;
        rst_n                 <= 1'b0;
        cfg_write_en          <= 1'b0;
        cfg_write_data        <= FMT_HEX;
        chars_if.valid        <= 1'b0;
        chars_if.char_code    <= '0;
        chars_if.char_present <= 1'b0;
        chars_if.last_char    <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings in the reset format, hex.
        send_char(code_t'($urandom), 1'b0, 1'b1);                 // empty string
        send_char(CHAR_ZERO, 1'b1, 1'b1);                         // lone zero
        send_char(CHAR_ZERO, 1'b1, 1'b0);                         // bare prefix
        send_char(CHAR_X, 1'b1, 1'b1);
        send_char(CHAR_ZERO, 1'b1, 1'b0);                         // prefix, minus, digits
        send_char(CHAR_X, 1'b1, 1'b0);
        send_char(CHAR_MINUS, 1'b1, 1'b0);
        send_char(CHAR_ZERO + 16'd1, 1'b1, 1'b0);
        send_char(CHAR_UPPER_F, 1'b1, 1'b1);
        send_char(CHAR_MINUS, 1'b1, 1'b1);                        // minus alone
        send_char(CHAR_ZERO, 1'b1, 1'b0);                         // held zero as a digit
        send_char(CHAR_ZERO + 16'd7, 1'b1, 1'b1);
        send_char(CHAR_ZERO, 1'b1, 1'b0);                         // zero, then minus stops
        send_char(CHAR_MINUS, 1'b1, 1'b1);
        send_char(CHAR_LOWER_A, 1'b1, 1'b0);                      // absent item inside
        send_char(16'hFFFF, 1'b0, 1'b0);
        send_char(CHAR_LOWER_F, 1'b1, 1'b1);
        send_char(CHAR_UPPER_F + 16'd1, 1'b1, 1'b0);              // non-digit first
        send_char(CHAR_ZERO + 16'd5, 1'b1, 1'b1);
        send_char(16'hFFFF, 1'b1, 1'b1);                          // wide code unit
        send_char(CHAR_ZERO + 16'd1, 1'b1, 1'b0);                 // code zero stops
        send_char(16'h0000, 1'b1, 1'b1);
        send_char(CHAR_X, 1'b1, 1'b0);                            // x without a zero
        send_char(CHAR_ZERO + 16'd1, 1'b1, 1'b1);
        send_char(CHAR_ZERO + 16'd5, 1'b1, 1'b0);                 // ends on an absent item
        send_char(16'h0000, 1'b0, 1'b1);

        // Random strings, one phase per format setting.
        foreach (format_plan[p])
        begin
            write_format(format_plan[p]);
            phase_start = requests_sent;
            while (requests_sent - phase_start < ITEMS_PER_PHASE)
                send_random_string(format_plan[p]);
        end

        wait_idle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog for a run that hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule : tb_top
